// File: hdl/midi_byte_to_usb_midi_packet_top_macros.svh
`ifndef MIDI_BYTE_TO_USB_MIDI_PACKET_TOP_MACROS_SVH
`define MIDI_BYTE_TO_USB_MIDI_PACKET_TOP_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define MB2UM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is low.
`define MB2UM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication that is checked during reset too.
`define MB2UM_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/mb2um_pkg.sv
package mb2um_pkg;

  localparam int unsigned CableW = 4;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned ByteW  = 8;

  // code index numbers
  localparam logic [CodeW-1:0] CIN_COMMON_TWO   = 4'h2;
  localparam logic [CodeW-1:0] CIN_COMMON_THREE = 4'h3;
  localparam logic [CodeW-1:0] CIN_SYSEX_CONT   = 4'h4;
  localparam logic [CodeW-1:0] CIN_END_ONE      = 4'h5;
  localparam logic [CodeW-1:0] CIN_END_TWO      = 4'h6;
  localparam logic [CodeW-1:0] CIN_END_THREE    = 4'h7;
  localparam logic [CodeW-1:0] CIN_SINGLE       = 4'hF;

  localparam logic [CodeW-1:0] NIB_SYSTEM       = 4'hF;
  localparam logic [CodeW-1:0] NIB_PROG_CHANGE  = 4'hC;
  localparam logic [CodeW-1:0] NIB_CHAN_PRESS   = 4'hD;

  // byte codes
  localparam logic [ByteW-1:0] BYTE_ZERO        = 8'h00;
  localparam logic [ByteW-1:0] SYSEX_START      = 8'hF0;
  localparam logic [ByteW-1:0] MTC_QUARTER      = 8'hF1;
  localparam logic [ByteW-1:0] SONG_POSITION    = 8'hF2;
  localparam logic [ByteW-1:0] SONG_SELECT      = 8'hF3;
  localparam logic [ByteW-1:0] SYSEX_END        = 8'hF7;
  localparam logic [ByteW-1:0] REALTIME_MIN     = 8'hF8;
  localparam logic [ByteW-1:0] BYTE_MAX         = 8'hFF;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_MSG   = 2'd1,
    MODE_SYSEX = 2'd2
  } mode_e;

  typedef struct packed {
    logic [CableW-1:0] cable;
    logic [CodeW-1:0]  code_index;
    logic [ByteW-1:0]  byte_one;
    logic [ByteW-1:0]  byte_two;
    logic [ByteW-1:0]  byte_three;
  } pkt_t;

endpackage

// File: hdl/mb2um_byte_if.sv
interface mb2um_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink   (input valid, input midi_byte, output ready);
endinterface

// File: hdl/mb2um_cfg_if.sv
interface mb2um_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] cable_number;

  modport source (output valid, output cable_number, input ready);
  modport sink   (input valid, input cable_number, output ready);
endinterface

// File: hdl/mb2um_pkt_if.sv
interface mb2um_pkt_if;
  logic       valid;
  logic       ready;
  logic [3:0] cable;
  logic [3:0] code_index;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic [7:0] byte_three;

  modport source (output valid, output cable, output code_index, output byte_one,
                  output byte_two, output byte_three, input ready);
  modport sink   (input valid, input cable, input code_index, input byte_one,
                  input byte_two, input byte_three, output ready);
endinterface

// File: hdl/mb2um_parser.sv
module mb2um_parser import mb2um_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [ByteW-1:0]  byte_i,
  input  logic [CableW-1:0] cable_i,
  output logic              emit_o,
  output pkt_t              pkt_o
);

  mode_e            mode_q, mode_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [1:0]       need_q, need_d;
  logic [1:0]       held_q, held_d;
  logic [ByteW-1:0] first_q, first_d;
  logic [ByteW-1:0] second_q, second_d;

  always_comb begin
    mode_d   = mode_q;
    code_d   = code_q;
    need_d   = need_q;
    held_d   = held_q;
    first_d  = first_q;
    second_d = second_q;
    emit_o   = 1'b0;
    pkt_o    = '{cable: cable_i, code_index: CIN_SINGLE, byte_one: byte_i,
                 byte_two: BYTE_ZERO, byte_three: BYTE_ZERO};

    if (byte_i inside {[REALTIME_MIN:BYTE_MAX]}) begin
      // real time: pass through, parse state untouched
      emit_o = 1'b1;
    end else if (byte_i == SYSEX_END) begin
      emit_o = 1'b1;
      mode_d = MODE_IDLE;
      held_d = 2'd0;
      if (mode_q == MODE_SYSEX) begin
        case (held_q)
          2'd0: begin
            pkt_o.code_index = CIN_END_ONE;
          end
          2'd1: begin
            pkt_o.code_index = CIN_END_TWO;
            pkt_o.byte_one   = first_q;
            pkt_o.byte_two   = SYSEX_END;
          end
          default: begin
            pkt_o.code_index = CIN_END_THREE;
            pkt_o.byte_one   = first_q;
            pkt_o.byte_two   = second_q;
            pkt_o.byte_three = SYSEX_END;
          end
        endcase
      end
    end else if (byte_i == SYSEX_START) begin
      mode_d  = MODE_SYSEX;
      first_d = SYSEX_START;
      held_d  = 2'd1;
    end else if (byte_i[7:4] == NIB_SYSTEM) begin
      if (byte_i inside {MTC_QUARTER, SONG_SELECT, SONG_POSITION}) begin
        mode_d  = MODE_MSG;
        code_d  = (byte_i == SONG_POSITION) ? CIN_COMMON_THREE : CIN_COMMON_TWO;
        need_d  = (byte_i == SONG_POSITION) ? 2'd2 : 2'd1;
        held_d  = 2'd0;
        first_d = byte_i;
      end else begin
        emit_o           = 1'b1;
        pkt_o.code_index = CIN_END_ONE;
        mode_d           = MODE_IDLE;
        held_d           = 2'd0;
      end
    end else if (byte_i[7]) begin
      mode_d  = MODE_MSG;
      code_d  = byte_i[7:4];
      need_d  = (byte_i[7:4] inside {NIB_PROG_CHANGE, NIB_CHAN_PRESS}) ? 2'd1 : 2'd2;
      held_d  = 2'd0;
      first_d = byte_i;
    end else begin
      case (mode_q)
        MODE_MSG: begin
          pkt_o.code_index = code_q;
          pkt_o.byte_one   = first_q;
          if (held_q == 2'd0 && need_q != 2'd1) begin
            second_d = byte_i;
            held_d   = 2'd1;
          end else begin
            emit_o = 1'b1;
            mode_d = MODE_IDLE;
            held_d = 2'd0;
            if (held_q == 2'd0) begin
              pkt_o.byte_two = byte_i;
            end else begin
              pkt_o.byte_two   = second_q;
              pkt_o.byte_three = byte_i;
            end
          end
        end
        MODE_SYSEX: begin
          case (held_q)
            2'd0: begin
              first_d = byte_i;
              held_d  = 2'd1;
            end
            2'd1: begin
              second_d = byte_i;
              held_d   = 2'd2;
            end
            default: begin
              emit_o           = 1'b1;
              held_d           = 2'd0;
              pkt_o.code_index = CIN_SYSEX_CONT;
              pkt_o.byte_one   = first_q;
              pkt_o.byte_two   = second_q;
              pkt_o.byte_three = byte_i;
            end
          endcase
        end
        default: begin
          // stray data byte: drop
          mode_d = MODE_IDLE;
          held_d = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      code_q   <= '0;
      need_q   <= '0;
      held_q   <= '0;
      first_q  <= '0;
      second_q <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      code_q   <= code_d;
      need_q   <= need_d;
      held_q   <= held_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

// File: hdl/midi_byte_to_usb_midi_packet_top.sv
// MIDI byte stream to USB-MIDI event packet converter.
// in_i carries one received MIDI byte per beat; pkt_o carries one 32-bit
// event packet per beat (cable, code index, three bytes, unused bytes zero).
// cfg_i writes the cable number; it is always ready and should be written
// only while no byte is in flight.
// A byte is held in an input register and parsed from there once the
// output register is free; the packet it completes is loaded into the
// output register, which drives pkt_o. Bytes that only advance the parse
// give no packet.
// One byte per cycle is taken sustained; the only limit is the single
// output register, which frees in the cycle that pkt_o is taken.
// When the receiver stalls, the output packet holds, the next byte parks in
// the input register, and in_i.ready drops until pkt_o.ready returns.
// Reset clears the parse to idle, empties both registers and sets the
// cable number to zero.
module midi_byte_to_usb_midi_packet_top import mb2um_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mb2um_cfg_if.sink cfg_i,
  mb2um_byte_if.sink in_i,
  mb2um_pkt_if.source pkt_o
);

  logic [CableW-1:0] cable_q;
  logic              in_valid_q;
  logic [ByteW-1:0]  byte_q;
  logic              out_valid_q;
  pkt_t              pkt_q;
  pkt_t              pkt_d;
  logic              emit;
  logic              out_free;
  logic              step;

  assign cfg_i.ready = 1'b1;

  assign out_free   = !out_valid_q || pkt_o.ready;
  assign step       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cable_q <= '0;
    end else if (cfg_i.valid) begin
      cable_q <= cfg_i.cable_number;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.midi_byte;
    end
  end

  mb2um_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (byte_q),
    .cable_i (cable_q),
    .emit_o  (emit),
    .pkt_o   (pkt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && emit;
    end
  end

  // load a new packet only when the slot is free and a byte completes one
  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_o.valid      = out_valid_q;
  assign pkt_o.cable      = pkt_q.cable;
  assign pkt_o.code_index = pkt_q.code_index;
  assign pkt_o.byte_one   = pkt_q.byte_one;
  assign pkt_o.byte_two   = pkt_q.byte_two;
  assign pkt_o.byte_three = pkt_q.byte_three;

endmodule

// File: hdl/mb2um_checker.sv
`include "midi_byte_to_usb_midi_packet_top_macros.svh"

module mb2um_checker import mb2um_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_valid_i,
  input logic              cfg_ready_i,
  input logic [CableW-1:0] cfg_cable_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CableW-1:0] out_cable_i,
  input logic [CodeW-1:0]  out_code_i,
  input logic [ByteW-1:0]  out_one_i,
  input logic [ByteW-1:0]  out_two_i,
  input logic [ByteW-1:0]  out_three_i
);

  logic [CableW-1:0]                 cable_q;
  logic [CableW+CodeW+3*ByteW-1:0]   out_beat;
  logic                              out_stall;
  logic                              channel_beat;
  logic                              single_beat;
  logic                              pad_zero;

  assign out_beat     = {out_cable_i, out_code_i, out_one_i, out_two_i, out_three_i};
  assign out_stall    = out_valid_i && !out_ready_i;
  assign channel_beat = out_valid_i && out_one_i[7] && (out_one_i[7:4] != NIB_SYSTEM);
  assign single_beat  = out_valid_i && (out_code_i == CIN_SINGLE);
  assign pad_zero     = (out_two_i == BYTE_ZERO) && (out_three_i == BYTE_ZERO);

  // track the last cable number written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cable_q <= '0;
    end else if (cfg_valid_i && cfg_ready_i) begin
      cable_q <= cfg_cable_i;
    end
  end

  `MB2UM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_beat))

  `MB2UM_ASSERT_IMPLY(a_cable_match, clk_i, rst_ni, out_valid_i, out_cable_i == cable_q)

  `MB2UM_ASSERT_IMPLY(a_channel_cin, clk_i, rst_ni, channel_beat, out_code_i == out_one_i[7:4])

  `MB2UM_ASSERT_IMPLY(a_single_pad, clk_i, rst_ni, single_beat, pad_zero)

  `MB2UM_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni, !out_valid_i)

endmodule

bind midi_byte_to_usb_midi_packet_top mb2um_checker u_mb2um_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_cable_i (cfg_i.cable_number),
  .out_valid_i (pkt_o.valid),
  .out_ready_i (pkt_o.ready),
  .out_cable_i (pkt_o.cable),
  .out_code_i  (pkt_o.code_index),
  .out_one_i   (pkt_o.byte_one),
  .out_two_i   (pkt_o.byte_two),
  .out_three_i (pkt_o.byte_three)
);
